### hw/rtl/box_frame_distance_assert.svh
// ----------------------------------------------------------------------------
// Box frame distance assertion macros
// Shared concurrent assertion forms clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef BOX_FRAME_DISTANCE_ASSERT_SVH
`define BOX_FRAME_DISTANCE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("box frame distance check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("box frame distance check failed");

`endif

### hw/rtl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// Box frame distance package
// Types and constants shared by the distance pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

  localparam int unsigned FrontStages = 4;
  localparam int unsigned SqrtStages  = 17;
  // Front stages, root stages, the edge term stage and the output register.
  localparam int unsigned PipeStages  = FrontStages + SqrtStages + 2;

  typedef enum logic [1:0] {
    RegHalfX = 2'd0,
    RegHalfY = 2'd1,
    RegHalfZ = 2'd2,
    RegThick = 2'd3
  } cfg_reg_e;

  typedef logic signed [15:0] pos_t;
  typedef logic [14:0]        cfg_t;
  typedef logic signed [17:0] dist_t;
  typedef logic signed [17:0] inner_t;
  typedef logic [33:0]        rad_t;
  typedef logic [16:0]        root_t;

  typedef struct packed {
    rad_t   [2:0] rad;
    inner_t [2:0] inner;
  } front_t;

endpackage

`default_nettype wire

### hw/rtl/bfd_front.sv
// ----------------------------------------------------------------------------
// Box frame distance front end
// Folds the point onto the frame, squares the clamped edge vectors and sums.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_front (
  input  logic            clk_i,
  input  logic            en_i,
  input  bfd_pkg::pos_t   pos_x_i,
  input  bfd_pkg::pos_t   pos_y_i,
  input  bfd_pkg::pos_t   pos_z_i,
  input  bfd_pkg::cfg_t   half_x_i,
  input  bfd_pkg::cfg_t   half_y_i,
  input  bfd_pkg::cfg_t   half_z_i,
  input  bfd_pkg::cfg_t   thick_i,
  output bfd_pkg::front_t front_o
);
  import bfd_pkg::*;

  function automatic logic [15:0] clamp0(logic signed [18:0] x);
    return x[18] ? 16'd0 : x[15:0];
  endfunction

  pos_t              pos [3];
  cfg_t              half [3];
  logic signed [17:0] p_d [3], p1_q [3], p2_q [3];
  logic signed [18:0] q_d [3], q2_q [3];
  cfg_t              t1_q;
  logic [31:0]       psq_d [3], qsq_d [3], psq_q [3], qsq_q [3];
  inner_t            inn_d [3], inn_q [3], inn4_q [3];
  rad_t              rad_d [3], rad_q [3];

  assign pos[0]  = pos_x_i;
  assign pos[1]  = pos_y_i;
  assign pos[2]  = pos_z_i;
  assign half[0] = half_x_i;
  assign half[1] = half_y_i;
  assign half[2] = half_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [17:0] ext, mag;
      logic signed [18:0] s, sa;
      ext = {{2{pos[a][15]}}, pos[a]};
      mag = ext[17] ? -ext : ext;
      p_d[a] = mag - $signed({3'b000, half[a]});
      s  = {p1_q[a][17], p1_q[a]} + $signed({4'b0000, t1_q});
      sa = s[18] ? -s : s;
      q_d[a] = sa - $signed({4'b0000, t1_q});
      psq_d[a] = 32'(clamp0({p2_q[a][17], p2_q[a]})) * 32'(clamp0({p2_q[a][17], p2_q[a]}));
      qsq_d[a] = 32'(clamp0(q2_q[a])) * 32'(clamp0(q2_q[a]));
    end
    // Edge term i keeps p on axis i and q on the other two axes.
    for (int i = 0; i < 3; i++) begin
      logic signed [18:0] mx, v;
      mx = (i == 0) ? {p2_q[0][17], p2_q[0]} : q2_q[0];
      for (int a = 1; a < 3; a++) begin
        v  = (i == a) ? {p2_q[a][17], p2_q[a]} : q2_q[a];
        mx = (v > mx) ? v : mx;
      end
      inn_d[i] = mx[18] ? mx[17:0] : '0;
      rad_d[i] = 34'((i == 0) ? psq_q[0] : qsq_q[0])
               + 34'((i == 1) ? psq_q[1] : qsq_q[1])
               + 34'((i == 2) ? psq_q[2] : qsq_q[2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= thick_i;
      for (int a = 0; a < 3; a++) begin
        p1_q[a]   <= p_d[a];
        p2_q[a]   <= p1_q[a];
        q2_q[a]   <= q_d[a];
        psq_q[a]  <= psq_d[a];
        qsq_q[a]  <= qsq_d[a];
        inn_q[a]  <= inn_d[a];
        inn4_q[a] <= inn_q[a];
        rad_q[a]  <= rad_d[a];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      front_o.rad[i]   = rad_q[i];
      front_o.inner[i] = inn4_q[i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bfd_sqrt.sv
// ----------------------------------------------------------------------------
// Box frame distance square root lane
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_sqrt (
  input  logic           clk_i,
  input  logic           en_i,
  input  bfd_pkg::rad_t  rad_i,
  input  bfd_pkg::inner_t inner_i,
  output bfd_pkg::root_t root_o,
  output bfd_pkg::inner_t inner_o
);
  import bfd_pkg::*;

  logic [17:0] rem_q  [SqrtStages];
  root_t       root_q [SqrtStages];
  rad_t        rad_q  [SqrtStages];
  inner_t      inn_q  [SqrtStages];

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    logic [17:0] rem_in;
    root_t       root_in;
    rad_t        rad_in;
    inner_t      inn_in;
    logic [19:0] work, trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign inn_in  = inner_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign inn_in  = inn_q[k-1];
    end

    assign work  = {rem_in, rad_in[33:32]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (work >= trial) begin
          rem_q[k]  <= 18'(work - trial);
          root_q[k] <= {root_in[15:0], 1'b1};
        end else begin
          rem_q[k]  <= work[17:0];
          root_q[k] <= {root_in[15:0], 1'b0};
        end
        rad_q[k] <= {rad_in[31:0], 2'b00};
        inn_q[k] <= inn_in;
      end
    end
  end

  assign root_o  = root_q[SqrtStages-1];
  assign inner_o = inn_q[SqrtStages-1];

endmodule

`default_nettype wire

### hw/rtl/box_frame_distance.sv
// ----------------------------------------------------------------------------
// Box frame distance
// Signed distance from a point to a hollow box frame centered at the origin.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   pos_x_i, pos_y_i, pos_z_i
//   output   out        out_valid_o / out_stall_i distance_o
//   config   in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item is taken per cycle while no finished result is blocked; its result
// passes through the four front stages, the 17 stages of the root lanes (one
// root bit each), the edge term stage and the output register.
// Reset clears the valid bits and loads the default frame geometry.
// The whole pipeline holds only while a result waits and out_stall_i is high;
// empty stages hold as well and do not close up, and nothing is dropped or
// repeated.
`default_nettype none

module box_frame_distance (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [14:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bfd_pkg::pos_t pos_x_i,
  input  bfd_pkg::pos_t pos_y_i,
  input  bfd_pkg::pos_t pos_z_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bfd_pkg::dist_t distance_o
);
  import bfd_pkg::*;

  cfg_t half_x_q, half_y_q, half_z_q, thick_q;
  logic [PipeStages-1:0] vld_q;
  logic en;
  logic hold;

  front_t front;
  root_t  root  [3];
  inner_t inner [3];
  logic signed [18:0] term_d [3], term_q [3];
  dist_t  dist_d, dist_q;

  // Configuration registers; the user must write them only while the pipeline is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_x_q <= 15'd256;
      half_y_q <= 15'd256;
      half_z_q <= 15'd256;
      thick_q  <= 15'd32;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegHalfX: half_x_q <= cfg_data_i;
        RegHalfY: half_y_q <= cfg_data_i;
        RegHalfZ: half_z_q <= cfg_data_i;
        RegThick: thick_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Global advance: everything moves unless a finished result is blocked.
  assign hold       = vld_q[PipeStages-1] & out_stall_i;
  assign en         = ~hold;
  assign in_stall_o = hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeStages-2:0], in_valid_i};
    end
  end

  bfd_front u_front (
    .clk_i    (clk_i),
    .en_i     (en),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .pos_z_i  (pos_z_i),
    .half_x_i (half_x_q),
    .half_y_i (half_y_q),
    .half_z_i (half_z_q),
    .thick_i  (thick_q),
    .front_o  (front)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    bfd_sqrt u_sqrt (
      .clk_i   (clk_i),
      .en_i    (en),
      .rad_i   (front.rad[i]),
      .inner_i (front.inner[i]),
      .root_o  (root[i]),
      .inner_o (inner[i])
    );
    assign term_d[i] = $signed({2'b00, root[i]}) + 19'(inner[i]);
  end

  // Least edge term, then clamp into the output range.
  always_comb begin
    logic signed [18:0] m;
    m = term_q[0];
    if (term_q[1] < m) m = term_q[1];
    if (term_q[2] < m) m = term_q[2];
    if (m > 19'sd131071) begin
      dist_d = 18'sd131071;
    end else if (m < -19'sd131072) begin
      dist_d = -18'sd131072;
    end else begin
      dist_d = m[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) term_q[i] <= term_d[i];
      dist_q <= dist_d;
    end
  end

  assign out_valid_o = vld_q[PipeStages-1];
  assign distance_o  = dist_q;

endmodule

`default_nettype wire

### hw/rtl/bfd_checker.sv
// ----------------------------------------------------------------------------
// Box frame distance checker
// Port level checks on stalls and result range, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_frame_distance_assert.svh"

module bfd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          cfg_we_i,
  input logic [1:0]    cfg_idx_i,
  input logic [14:0]   cfg_data_i,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input bfd_pkg::pos_t pos_x_i,
  input bfd_pkg::pos_t pos_y_i,
  input bfd_pkg::pos_t pos_z_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bfd_pkg::dist_t distance_o
);

  // A blocked result stays in place.
  `BFD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(distance_o))
  // Input is refused only while a finished result is blocked.
  `BFD_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  // The largest component of an edge vector is never below minus the max half size.
  `BFD_ASSERT_SAME(a_dist_floor, out_valid_o, $signed(distance_o) >= -18'sd32767)

endmodule

bind box_frame_distance bfd_checker u_bfd_checker (.*);

`default_nettype wire

### dv/box_frame_distance_checker.sv
// ----------------------------------------------------------------------------
// Box frame distance checker
// Watches both channels of the distance block, predicts every accepted point
// and compares each distance that leaves with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module box_frame_distance_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [14:0]    cfg_data_i,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  bfd_pkg::pos_t  pos_x_i,
  input  bfd_pkg::pos_t  pos_y_i,
  input  bfd_pkg::pos_t  pos_z_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  bfd_pkg::dist_t distance_i,
  output int             fail_count_o,
  output int             pending_o
);
  import bfd_pkg::*;

  cfg_t   half_x, half_y, half_z, thick;
  dist_t  dist_queue[$];
  int     fails;

  assign fail_count_o = fails;
  assign pending_o    = dist_queue.size();

  function automatic longint floor_root(longint n);
    longint r;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n) r += longint'(1) << b;
    end
    return r;
  endfunction

  function automatic longint edge_len(longint a, longint b, longint c);
    longint ca, cb, cc, m;
    ca = a > 0 ? a : 0;
    cb = b > 0 ? b : 0;
    cc = c > 0 ? c : 0;
    m = a > b ? a : b;
    m = m > c ? m : c;
    if (m > 0) m = 0;
    return floor_root(ca * ca + cb * cb + cc * cc) + m;
  endfunction

  function automatic dist_t frame_distance(pos_t x, pos_t y, pos_t z);
    longint t, px, py, pz, qx, qy, qz, d, e;
    t  = thick;
    px = (x < 0 ? -longint'(x) : longint'(x)) - half_x;
    py = (y < 0 ? -longint'(y) : longint'(y)) - half_y;
    pz = (z < 0 ? -longint'(z) : longint'(z)) - half_z;
    qx = ((px + t) < 0 ? -(px + t) : px + t) - t;
    qy = ((py + t) < 0 ? -(py + t) : py + t) - t;
    qz = ((pz + t) < 0 ? -(pz + t) : pz + t) - t;
    d = edge_len(px, qy, qz);
    e = edge_len(qx, py, qz);
    if (e < d) d = e;
    e = edge_len(qx, qy, pz);
    if (e < d) d = e;
    if (d > 131071) d = 131071;
    if (d < -131072) d = -131072;
    return dist_t'(d);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dist_t want;
    if (!rst_ni) begin
      half_x <= 15'd256;
      half_y <= 15'd256;
      half_z <= 15'd256;
      thick  <= 15'd32;
      fails  = 0;
      dist_queue.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        dist_queue.push_back(frame_distance(pos_x_i, pos_y_i, pos_z_i));
      if (out_valid_i && !out_stall_i) begin
        if (dist_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected distance %0d", distance_i));
        end else begin
          want = dist_queue.pop_front();
          if (want !== distance_i)
            report_mismatch($sformatf("distance %0d, expected %0d", distance_i, want));
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegHalfX: half_x <= cfg_data_i;
          RegHalfY: half_y <= cfg_data_i;
          RegHalfZ: half_z <= cfg_data_i;
          RegThick: thick  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Box frame distance testbench
// Drives directed and random points through several frame geometries with
// random idling on both sides; a checker beside the block does the scoring.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import bfd_pkg::*;

  localparam int Latency    = PipeStages + 4;
  localparam int CycleLimit = 400000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [14:0] cfg_data_i = '0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  pos_t  pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  dist_t distance_o;
  int    fail_count, pending, cycle_count;
  // Random idling is switched off for the last part of the run.
  bit    calm = 1'b0;
  // Set while the receiver holds off for a long stretch.
  bit    hold_off = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  box_frame_distance dut (.*);

  box_frame_distance_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .pos_x_i, .pos_y_i, .pos_z_i,
    .out_valid_i(out_valid_o), .out_stall_i, .distance_i(distance_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The run ends here if the block stops making progress.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [14:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_frame(logic [14:0] hx, logic [14:0] hy, logic [14:0] hz,
                           logic [14:0] t);
    write_reg(RegHalfX, hx);
    write_reg(RegHalfY, hy);
    write_reg(RegHalfZ, hz);
    write_reg(RegThick, t);
  endtask

  // Offers one point and holds it until accepted; the sender may idle first.
  task automatic send_point(pos_t x, pos_t y, pos_t z);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
  endtask

  // Mostly coordinates near the frame, sometimes anywhere in the field.
  function automatic pos_t pick_coord(logic [14:0] half);
    int v;
    if ($urandom_range(0, 3) == 0) return pos_t'($urandom);
    v = int'(half) + $urandom_range(0, 1024) - 512;
    if ($urandom_range(0, 1)) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return pos_t'(v);
  endfunction

  task automatic random_points(int count, logic [14:0] hx, logic [14:0] hy,
                               logic [14:0] hz);
    repeat (count) send_point(pick_coord(hx), pick_coord(hy), pick_coord(hz));
  endtask

  initial begin
    logic [14:0] hx, hy, hz, t;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed points under the reset geometry: origin, extremes, the most
    // negative coordinate, points on the edges, faces and corners.
    send_point(16'sd0, 16'sd0, 16'sd0);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    send_point(-16'sd32768, 16'sd0, 16'sh7fff);
    send_point(16'sd256, 16'sd256, 16'sd256);
    send_point(-16'sd256, 16'sd256, -16'sd256);
    send_point(16'sd256, 16'sd256, 16'sd0);
    send_point(16'sd0, 16'sd256, 16'sd256);
    send_point(16'sd256, 16'sd0, 16'sd256);
    send_point(16'sd240, 16'sd240, 16'sd10);
    send_point(16'sd288, 16'sd300, -16'sd400);
    send_point(16'sd224, 16'sd0, 16'sd0);
    send_point(-16'sd1, -16'sd1, -16'sd1);
    drain();

    // Degenerate geometry: zero sizes and thickness, then the largest ones.
    set_frame(15'd0, 15'd0, 15'd0, 15'd0);
    send_point(16'sd0, 16'sd0, 16'sd0);
    send_point(-16'sd32768, 16'sh7fff, 16'sd5);
    send_point(16'sd100, -16'sd100, 16'sd0);
    drain();
    set_frame(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
    send_point(16'sd0, 16'sd0, 16'sd0);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    send_point(16'sh7fff, 16'sd0, -16'sd32768);
    send_point(16'sd1234, -16'sd4321, 16'sd77);
    drain();

    // Long receiver hold-off while the sender keeps offering points.
    set_frame(15'd256, 15'd256, 15'd256, 15'd32);
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_points(120, 15'd256, 15'd256, 15'd256);
    join
    drain();

    // Random geometries, the extremes among them.
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin hx = 15'h7fff; hy = 15'd0; hz = 15'd300; t = 15'h7fff; end
        1: begin hx = 15'd0; hy = 15'h7fff; hz = 15'd0; t = 15'd0; end
        default: begin
          hx = 15'($urandom_range(0, 8192));
          hy = 15'($urandom_range(0, 8192));
          hz = 15'($urandom_range(0, 8192));
          t  = 15'($urandom_range(0, 2048));
          if (phase % 4 == 3) begin
            hx = 15'($urandom);
            hy = 15'($urandom);
            hz = 15'($urandom);
            t  = 15'($urandom);
          end
        end
      endcase
      set_frame(hx, hy, hz, t);
      if (phase == 11) calm = 1'b1;
      random_points(145, hx, hy, hz);
      drain();
    end

    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
